[design/bffla_pkg.sv]
`default_nettype none

package bffla_pkg;

  localparam int ADDR_BITS    = 24;
  localparam int LEN_BITS     = 25;
  localparam int BE_BITS      = LEN_BITS + 1;
  localparam int ADJ_BITS     = 8;
  localparam int HANDLE_COUNT = 64;
  localparam int HANDLE_BITS  = 6;
  localparam int POOL_RESET   = 65536;
  localparam int POOL_MIN     = 32;
  localparam int POOL_MAX     = 1 << ADDR_BITS;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_NO_HANDLE  = 3'd1;
  localparam logic [2:0] STAT_NO_SPACE   = 3'd2;
  localparam logic [2:0] STAT_FRAGMENTED = 3'd3;
  localparam logic [2:0] STAT_TABLE_FULL = 3'd4;
  localparam logic [2:0] STAT_BAD_HANDLE = 3'd5;

  localparam logic [4:0] ACT_NONE   = 5'd0;
  localparam logic [4:0] ACT_INIT   = 5'd1;
  localparam logic [4:0] ACT_LOAD   = 5'd2;
  localparam logic [4:0] ACT_CHECK  = 5'd3;
  localparam logic [4:0] ACT_AEVAL  = 5'd4;
  localparam logic [4:0] ACT_NOFIT  = 5'd5;
  localparam logic [4:0] ACT_ADEC   = 5'd6;
  localparam logic [4:0] ACT_POP    = 5'd7;
  localparam logic [4:0] ACT_DNWR   = 5'd8;
  localparam logic [4:0] ACT_CNTDEC = 5'd9;
  localparam logic [4:0] ACT_FHRD   = 5'd10;
  localparam logic [4:0] ACT_FEVAL  = 5'd11;
  localparam logic [4:0] ACT_FULL   = 5'd12;
  localparam logic [4:0] ACT_FDEC   = 5'd13;
  localparam logic [4:0] ACT_UPWR   = 5'd14;
  localparam logic [4:0] ACT_UPPUT  = 5'd15;
  localparam logic [4:0] ACT_OUT    = 5'd16;

  typedef struct packed {
    logic [4:0] act;
  } cmd_t;

  typedef struct packed {
    logic alloc;
    logic no_handle;
    logic bad;
    logic ptr_end;
    logic exact;
    logic found;
    logic rm;
    logic lt_be;
    logic mp;
    logic mn;
    logic full;
    logic up_at_p;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

[design/bffla_dp.sv]
`default_nettype none

module bffla_dp
  import bffla_pkg::*;
#(
  parameter int HEADER_BYTES = 16,
  parameter int FREE_BLOCKS  = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEN_BITS-1:0]    cfg_wdata_i,
  input  wire logic                   opcode_i,
  input  wire logic [ADDR_BITS-1:0]   req_size_i,
  input  wire logic [7:0]             align_bytes_i,
  input  wire logic [HANDLE_BITS-1:0] handle_i,
  input  wire logic                   out_stall_i,
  output logic                        out_valid_o,
  output logic [2:0]                  status_o,
  output logic [HANDLE_BITS-1:0]      handle_out_o,
  output logic [ADDR_BITS-1:0]        address_o,
  output logic [LEN_BITS-1:0]         block_bytes_o,
  output logic [LEN_BITS-1:0]         used_bytes_o,
  output logic [HANDLE_BITS-1:0]      allocation_count_o,
  output logic                        needs_defrag_o
);

  localparam int IDX_W = $clog2(FREE_BLOCKS);
  localparam int CNT_W = $clog2(FREE_BLOCKS + 1);
  localparam int TF_W  = LEN_BITS + CNT_W;

  logic [ADDR_BITS-1:0]   ft_s_mem [FREE_BLOCKS];
  logic [LEN_BITS-1:0]    ft_l_mem [FREE_BLOCKS];
  logic [ADDR_BITS-1:0]   hm_a_mem [HANDLE_COUNT];
  logic [LEN_BITS-1:0]    hm_l_mem [HANDLE_COUNT];
  logic [ADJ_BITS-1:0]    hm_j_mem [HANDLE_COUNT];
  logic [HANDLE_BITS-1:0] sk_mem   [HANDLE_COUNT];

  logic [LEN_BITS-1:0]    pool_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [HANDLE_BITS-1:0] top_q, low_q;
  logic [LEN_BITS-1:0]    bytes_q;
  logic [HANDLE_BITS-1:0] lcnt_q;
  logic [HANDLE_COUNT-1:0] live_q;
  logic [ADDR_BITS-1:0]   e0s_q;
  logic [LEN_BITS-1:0]    e0l_q;

  logic                   op_q;
  logic [ADDR_BITS-1:0]   size_q;
  logic [7:0]             align_q;
  logic [HANDLE_BITS-1:0] hin_q;

  logic [CNT_W-1:0]       ptr_q, p_q;
  logic                   found_q, rm_q, up_q;
  logic [CNT_W-1:0]       bidx_q;
  logic [ADDR_BITS-1:0]   bstart_q;
  logic [LEN_BITS-1:0]    blen_q;
  logic [ADJ_BITS-1:0]    badj_q;
  logic [TF_W-1:0]        tfree_q;
  logic [LEN_BITS-1:0]    tot_q;

  logic [ADDR_BITS-1:0]   bs_q;
  logic [LEN_BITS-1:0]    sz_q;
  logic [BE_BITS-1:0]     be_q;
  logic                   hp_q, hn_q;
  logic [ADDR_BITS-1:0]   ps_q, ns_q;
  logic [LEN_BITS-1:0]    pl_q, nl_q;

  logic [2:0]             rstat_q;
  logic [HANDLE_BITS-1:0] rhand_q;
  logic [ADDR_BITS-1:0]   raddr_q;
  logic [LEN_BITS-1:0]    rbytes_q;

  logic [ADDR_BITS-1:0]   rds_q, hadr_q;
  logic [LEN_BITS-1:0]    rdl_q, hlen_q;
  logic [ADJ_BITS-1:0]    hadj_q;
  logic [HANDLE_BITS-1:0] sk_rd_q;

  logic                   out_valid_q;
  logic [2:0]             ostat_q;
  logic [HANDLE_BITS-1:0] ohand_q, ocnt_q;
  logic [ADDR_BITS-1:0]   oaddr_q;
  logic [LEN_BITS-1:0]    obytes_q, oused_q;
  logic                   odefrag_q;

  logic [7:0]             align_n;
  logic [7:0]             amask;
  logic [7:0]             xlow, adj_c;
  logic [LEN_BITS-1:0]    tot_c, btot, brem;
  logic [CNT_W-1:0]       ptr_m1;
  logic [IDX_W-1:0]       ft_ra, ft_wa;
  logic                   ft_we;
  logic [ADDR_BITS-1:0]   ft_ws;
  logic [LEN_BITS-1:0]    ft_wl;
  logic [HANDLE_BITS-1:0] h_new;
  logic                   mp_c, mn_c, defrag_c;
  logic [LEN_BITS-1:0]    pool_sat;
  logic [ADDR_BITS-1:0]   bs_c;

  always_comb begin
    align_n = 8'd1;
    for (int i = 0; i < 8; i++) begin
      if (align_bytes_i[i]) begin
        align_n = 8'd1 << i;
      end
    end
  end

  always_comb begin
    if (cfg_wdata_i < LEN_BITS'(POOL_MIN)) begin
      pool_sat = LEN_BITS'(POOL_MIN);
    end else if (cfg_wdata_i > LEN_BITS'(POOL_MAX)) begin
      pool_sat = LEN_BITS'(POOL_MAX);
    end else begin
      pool_sat = cfg_wdata_i;
    end
  end

  assign amask  = align_q - 8'd1;
  assign xlow   = rds_q[7:0] + 8'(HEADER_BYTES);
  assign adj_c  = ((8'd0 - xlow) & amask) + 8'(HEADER_BYTES);
  assign tot_c  = LEN_BITS'(size_q) + LEN_BITS'(adj_c);
  assign btot   = LEN_BITS'(size_q) + LEN_BITS'(badj_q);
  assign brem   = blen_q - btot;
  assign ptr_m1 = ptr_q - CNT_W'(1);
  assign ft_ra  = up_q ? ptr_m1[IDX_W-1:0] : ptr_q[IDX_W-1:0];
  assign h_new  = (top_q == low_q) ? HANDLE_BITS'(HANDLE_COUNT - int'(top_q)) : sk_rd_q;
  assign bs_c   = hadr_q - ADDR_BITS'(hadj_q);
  assign mp_c   = hp_q && (BE_BITS'(ps_q) + BE_BITS'(pl_q) == BE_BITS'(bs_q));
  assign mn_c   = hn_q && (BE_BITS'(ns_q) == be_q);
  assign defrag_c = !((cnt_q == '0) ||
                      ((cnt_q == CNT_W'(1)) &&
                       (BE_BITS'(e0s_q) + BE_BITS'(e0l_q) == BE_BITS'(pool_q))));

  always_comb begin
    ft_we = 1'b0;
    ft_wa = '0;
    ft_ws = '0;
    ft_wl = '0;
    case (cmd_i.act)
      ACT_INIT: begin
        ft_we = 1'b1;
        ft_wl = pool_q;
      end
      ACT_ADEC: begin
        if (brem > LEN_BITS'(HEADER_BYTES)) begin
          ft_we = 1'b1;
          ft_wa = bidx_q[IDX_W-1:0];
          ft_ws = bstart_q + btot[ADDR_BITS-1:0];
          ft_wl = brem;
        end
      end
      ACT_DNWR: begin
        ft_we = 1'b1;
        ft_wa = ptr_m1[IDX_W-1:0];
        ft_ws = rds_q;
        ft_wl = rdl_q;
      end
      ACT_FDEC: begin
        if (mp_c) begin
          ft_we = 1'b1;
          ft_wa = ptr_m1[IDX_W-1:0];
          ft_ws = ps_q;
          ft_wl = mn_c ? (pl_q + sz_q + nl_q) : (pl_q + sz_q);
        end else if (mn_c) begin
          ft_we = 1'b1;
          ft_wa = ptr_q[IDX_W-1:0];
          ft_ws = bs_q;
          ft_wl = nl_q + sz_q;
        end
      end
      ACT_UPWR: begin
        ft_we = 1'b1;
        ft_wa = ptr_q[IDX_W-1:0];
        ft_ws = rds_q;
        ft_wl = rdl_q;
      end
      ACT_UPPUT: begin
        ft_we = 1'b1;
        ft_wa = ptr_q[IDX_W-1:0];
        ft_ws = bs_q;
        ft_wl = sz_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ft_we) begin
      ft_s_mem[ft_wa] <= ft_ws;
      ft_l_mem[ft_wa] <= ft_wl;
    end
    rds_q <= ft_s_mem[ft_ra];
    rdl_q <= ft_l_mem[ft_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_POP) begin
      hm_a_mem[h_new] <= bstart_q + ADDR_BITS'(badj_q);
      hm_l_mem[h_new] <= tot_q;
      hm_j_mem[h_new] <= badj_q;
    end
    hadr_q <= hm_a_mem[hin_q];
    hlen_q <= hm_l_mem[hin_q];
    hadj_q <= hm_j_mem[hin_q];
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.act == ACT_FDEC) && (top_q < HANDLE_BITS'(HANDLE_COUNT - 1))) begin
      sk_mem[top_q] <= hin_q;
    end
    sk_rd_q <= sk_mem[top_q - HANDLE_BITS'(1)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= LEN_BITS'(POOL_RESET);
      cnt_q       <= CNT_W'(1);
      top_q       <= HANDLE_BITS'(HANDLE_COUNT - 1);
      low_q       <= HANDLE_BITS'(HANDLE_COUNT - 1);
      bytes_q     <= '0;
      lcnt_q      <= '0;
      live_q      <= '0;
      e0s_q       <= '0;
      e0l_q       <= LEN_BITS'(POOL_RESET);
      op_q        <= OP_ALLOC;
      size_q      <= '0;
      align_q     <= 8'd1;
      hin_q       <= '0;
      ptr_q       <= '0;
      p_q         <= '0;
      found_q     <= 1'b0;
      rm_q        <= 1'b0;
      up_q        <= 1'b0;
      bidx_q      <= '0;
      bstart_q    <= '0;
      blen_q      <= '0;
      badj_q      <= '0;
      tfree_q     <= '0;
      tot_q       <= '0;
      bs_q        <= '0;
      sz_q        <= '0;
      be_q        <= '0;
      hp_q        <= 1'b0;
      hn_q        <= 1'b0;
      ps_q        <= '0;
      pl_q        <= '0;
      ns_q        <= '0;
      nl_q        <= '0;
      rstat_q     <= STAT_OK;
      rhand_q     <= '0;
      raddr_q     <= '0;
      rbytes_q    <= '0;
      out_valid_q <= 1'b0;
      ostat_q     <= STAT_OK;
      ohand_q     <= '0;
      ocnt_q      <= '0;
      oaddr_q     <= '0;
      obytes_q    <= '0;
      oused_q     <= '0;
      odefrag_q   <= 1'b0;
    end else begin
      if (ft_we && (ft_wa == '0)) begin
        e0s_q <= ft_ws;
        e0l_q <= ft_wl;
      end
      if (out_valid_q && !out_stall_i && (cfg_we_i || (cmd_i.act != ACT_OUT))) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pool_q  <= pool_sat;
        cnt_q   <= CNT_W'(1);
        top_q   <= HANDLE_BITS'(HANDLE_COUNT - 1);
        low_q   <= HANDLE_BITS'(HANDLE_COUNT - 1);
        bytes_q <= '0;
        lcnt_q  <= '0;
        live_q  <= '0;
      end else begin
        case (cmd_i.act)
          ACT_LOAD: begin
            op_q    <= opcode_i;
            size_q  <= req_size_i;
            align_q <= align_n;
            hin_q   <= handle_i;
          end
          ACT_CHECK: begin
            ptr_q    <= '0;
            found_q  <= 1'b0;
            rm_q     <= 1'b0;
            up_q     <= 1'b0;
            tfree_q  <= '0;
            hp_q     <= 1'b0;
            hn_q     <= 1'b0;
            rhand_q  <= '0;
            raddr_q  <= '0;
            rbytes_q <= '0;
            if ((op_q == OP_ALLOC) && (top_q == '0)) begin
              rstat_q <= STAT_NO_HANDLE;
            end else if ((op_q == OP_FREE) && ((hin_q == '0) || !live_q[hin_q])) begin
              rstat_q <= STAT_BAD_HANDLE;
            end else begin
              rstat_q <= STAT_OK;
            end
          end
          ACT_AEVAL: begin
            tfree_q <= tfree_q + TF_W'(rdl_q);
            if ((rdl_q == tot_c) ||
                ((rdl_q > tot_c) && (!found_q || (rdl_q < blen_q)))) begin
              found_q  <= 1'b1;
              bidx_q   <= ptr_q;
              bstart_q <= rds_q;
              blen_q   <= rdl_q;
              badj_q   <= adj_c;
            end
            ptr_q <= ptr_q + CNT_W'(1);
          end
          ACT_NOFIT: begin
            if (tfree_q >= TF_W'(size_q) + TF_W'(align_q)) begin
              rstat_q <= STAT_FRAGMENTED;
            end else begin
              rstat_q <= STAT_NO_SPACE;
            end
          end
          ACT_ADEC: begin
            if (brem > LEN_BITS'(HEADER_BYTES)) begin
              tot_q <= btot;
              rm_q  <= 1'b0;
            end else begin
              tot_q <= blen_q;
              rm_q  <= 1'b1;
              ptr_q <= bidx_q + CNT_W'(1);
            end
          end
          ACT_POP: begin
            live_q[h_new] <= 1'b1;
            bytes_q       <= bytes_q + tot_q;
            lcnt_q        <= lcnt_q + HANDLE_BITS'(1);
            top_q         <= top_q - HANDLE_BITS'(1);
            if (top_q == low_q) begin
              low_q <= top_q - HANDLE_BITS'(1);
            end
            rstat_q  <= STAT_OK;
            rhand_q  <= h_new;
            raddr_q  <= bstart_q + ADDR_BITS'(badj_q);
            rbytes_q <= tot_q;
          end
          ACT_DNWR: begin
            ptr_q <= ptr_q + CNT_W'(1);
          end
          ACT_CNTDEC: begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
          ACT_FHRD: begin
            bs_q <= bs_c;
            sz_q <= hlen_q;
            be_q <= BE_BITS'(bs_c) + BE_BITS'(hlen_q);
          end
          ACT_FEVAL: begin
            if (BE_BITS'(rds_q) < be_q) begin
              hp_q  <= 1'b1;
              ps_q  <= rds_q;
              pl_q  <= rdl_q;
              ptr_q <= ptr_q + CNT_W'(1);
            end else begin
              hn_q <= 1'b1;
              ns_q <= rds_q;
              nl_q <= rdl_q;
            end
          end
          ACT_FULL: begin
            rstat_q <= STAT_TABLE_FULL;
          end
          ACT_FDEC: begin
            p_q <= ptr_q;
            if (mp_c && mn_c) begin
              ptr_q <= ptr_q + CNT_W'(1);
            end else if (!mp_c && !mn_c) begin
              ptr_q <= cnt_q;
              up_q  <= 1'b1;
            end
            live_q[hin_q] <= 1'b0;
            if (top_q < HANDLE_BITS'(HANDLE_COUNT - 1)) begin
              top_q <= top_q + HANDLE_BITS'(1);
            end
            bytes_q <= bytes_q - sz_q;
            if (lcnt_q != '0) begin
              lcnt_q <= lcnt_q - HANDLE_BITS'(1);
            end
          end
          ACT_UPWR: begin
            ptr_q <= ptr_m1;
          end
          ACT_UPPUT: begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          ACT_OUT: begin
            out_valid_q <= 1'b1;
            ostat_q     <= rstat_q;
            ohand_q     <= rhand_q;
            oaddr_q     <= raddr_q;
            obytes_q    <= rbytes_q;
            oused_q     <= bytes_q;
            ocnt_q      <= lcnt_q;
            odefrag_q   <= defrag_c;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    sts_o.alloc     = (op_q == OP_ALLOC);
    sts_o.no_handle = (top_q == '0);
    sts_o.bad       = (hin_q == '0) || !live_q[hin_q];
    sts_o.ptr_end   = (ptr_q >= cnt_q);
    sts_o.exact     = (rdl_q == tot_c);
    sts_o.found     = found_q;
    sts_o.rm        = rm_q;
    sts_o.lt_be     = (BE_BITS'(rds_q) < be_q);
    sts_o.mp        = mp_c;
    sts_o.mn        = mn_c;
    sts_o.full      = !mp_c && !mn_c && (cnt_q >= CNT_W'(FREE_BLOCKS));
    sts_o.up_at_p   = (ptr_q == p_q);
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = ostat_q;
  assign handle_out_o       = ohand_q;
  assign address_o          = oaddr_q;
  assign block_bytes_o      = obytes_q;
  assign used_bytes_o       = oused_q;
  assign allocation_count_o = ocnt_q;
  assign needs_defrag_o     = odefrag_q;

endmodule

`default_nettype wire

[design/bffla_ctrl.sv]
`default_nettype none

module bffla_ctrl
  import bffla_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic cfg_we_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_AEVAL = 4'd4;
  localparam logic [3:0] S_ADEC  = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_DNRD  = 4'd7;
  localparam logic [3:0] S_DNWR  = 4'd8;
  localparam logic [3:0] S_FHRD  = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FEVAL = 4'd11;
  localparam logic [3:0] S_FDEC  = 4'd12;
  localparam logic [3:0] S_UPRD  = 4'd13;
  localparam logic [3:0] S_UPWR  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE) || cfg_we_i;

  always_comb begin
    state_d   = state_q;
    cmd_o.act = ACT_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o.act = ACT_INIT;
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !cfg_we_i) begin
          cmd_o.act = ACT_LOAD;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.act = ACT_CHECK;
        if (sts_i.alloc) begin
          state_d = sts_i.no_handle ? S_DONE : S_ARD;
        end else begin
          state_d = sts_i.bad ? S_DONE : S_FHRD;
        end
      end
      S_ARD: begin
        state_d = sts_i.ptr_end ? S_ADEC : S_AEVAL;
      end
      S_AEVAL: begin
        cmd_o.act = ACT_AEVAL;
        state_d   = sts_i.exact ? S_ADEC : S_ARD;
      end
      S_ADEC: begin
        if (sts_i.found) begin
          cmd_o.act = ACT_ADEC;
          state_d   = S_POP;
        end else begin
          cmd_o.act = ACT_NOFIT;
          state_d   = S_DONE;
        end
      end
      S_POP: begin
        cmd_o.act = ACT_POP;
        state_d   = sts_i.rm ? S_DNRD : S_DONE;
      end
      S_DNRD: begin
        if (sts_i.ptr_end) begin
          cmd_o.act = ACT_CNTDEC;
          state_d   = S_DONE;
        end else begin
          state_d = S_DNWR;
        end
      end
      S_DNWR: begin
        cmd_o.act = ACT_DNWR;
        state_d   = S_DNRD;
      end
      S_FHRD: begin
        cmd_o.act = ACT_FHRD;
        state_d   = S_FRD;
      end
      S_FRD: begin
        state_d = sts_i.ptr_end ? S_FDEC : S_FEVAL;
      end
      S_FEVAL: begin
        cmd_o.act = ACT_FEVAL;
        state_d   = sts_i.lt_be ? S_FRD : S_FDEC;
      end
      S_FDEC: begin
        if (sts_i.full) begin
          cmd_o.act = ACT_FULL;
          state_d   = S_DONE;
        end else begin
          cmd_o.act = ACT_FDEC;
          if (sts_i.mp && sts_i.mn) begin
            state_d = S_DNRD;
          end else if (sts_i.mp || sts_i.mn) begin
            state_d = S_DONE;
          end else begin
            state_d = S_UPRD;
          end
        end
      end
      S_UPRD: begin
        if (sts_i.up_at_p) begin
          cmd_o.act = ACT_UPPUT;
          state_d   = S_DONE;
        end else begin
          state_d = S_UPWR;
        end
      end
      S_UPWR: begin
        cmd_o.act = ACT_UPWR;
        state_d   = S_UPRD;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.act = ACT_OUT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      cmd_o.act = ACT_NONE;
      state_d   = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/best_fit_free_list_allocator.sv]
// Best-fit allocator over one pool, one item at a time. An allocate scans
// the free table entry by entry (the table is a memory with one write port
// and a registered read) and moves entries when a block is taken whole; a
// free scans the table up to the insertion point and moves entries on an
// insert or a double merge. After reset or a pool_size write the block
// rebuilds the first free entry in its init state before it takes an item.

`default_nettype none

module best_fit_free_list_allocator
  import bffla_pkg::*;
#(
  parameter int HEADER_BYTES = 16,
  parameter int FREE_BLOCKS  = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEN_BITS-1:0]    cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   opcode_i,
  input  wire logic [ADDR_BITS-1:0]   req_size_i,
  input  wire logic [7:0]             align_bytes_i,
  input  wire logic [HANDLE_BITS-1:0] handle_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic [HANDLE_BITS-1:0]      handle_out_o,
  output logic [ADDR_BITS-1:0]        address_o,
  output logic [LEN_BITS-1:0]         block_bytes_o,
  output logic [LEN_BITS-1:0]         used_bytes_o,
  output logic [HANDLE_BITS-1:0]      allocation_count_o,
  output logic                        needs_defrag_o
);

  cmd_t cmd;
  sts_t sts;

  bffla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bffla_dp #(
    .HEADER_BYTES (HEADER_BYTES),
    .FREE_BLOCKS  (FREE_BLOCKS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .opcode_i           (opcode_i),
    .req_size_i         (req_size_i),
    .align_bytes_i      (align_bytes_i),
    .handle_i           (handle_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .handle_out_o       (handle_out_o),
    .address_o          (address_o),
    .block_bytes_o      (block_bytes_o),
    .used_bytes_o       (used_bytes_o),
    .allocation_count_o (allocation_count_o),
    .needs_defrag_o     (needs_defrag_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in progress");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |->
      (handle_out_o == '0) && (block_bytes_o == '0) && (address_o == '0))
    else $error("failed request carries grant fields");

  a_grant_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_OK) && (block_bytes_o != '0) |->
      (handle_out_o != '0) && (allocation_count_o != '0))
    else $error("grant without a live handle");

endmodule

`default_nettype wire
